@@ rtl/stok_pkg.sv @@
// ----------------------------------------------------------------------------
// stok_pkg: shared types and helpers for the source tokenizer
// Token kinds, scan modes, result burst layout and byte class functions.
// ----------------------------------------------------------------------------
package stok_pkg;

   localparam int MAX_FIELD_BYTES = 65536;
   localparam int OFS_W           = $clog2(MAX_FIELD_BYTES + 1);
   localparam int VAL_W           = 63;
   localparam int KIND_W          = 6;
   localparam int FIELD_W         = 16;
   localparam int FIELD_MAX       = 2**FIELD_W - 1;
   localparam int MAX_RES         = 4;
   localparam int CNT_W           = $clog2(MAX_RES + 1);
   localparam int RD_W            = $clog2(MAX_RES);
   localparam int CHAR_W          = 8;
   localparam int ACT_W           = 2;
   localparam int MATCH_W         = 3;

   localparam int RSP_FIELDS_W    = FIELD_W + FIELD_W + VAL_W + FIELD_W;
   localparam int RSP_DATA_W      = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_IDX_W       = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_TAG = '0;

   typedef logic [OFS_W-1:0] ofs_type;

   localparam ofs_type OFS_MAX = ofs_type'(MAX_FIELD_BYTES);
   localparam ofs_type OFS_ONE = ofs_type'(1);
   localparam ofs_type OFS_TWO = ofs_type'(2);

   localparam logic [ACT_W-1:0] ACT_BYTE     = 2'd0;
   localparam logic [ACT_W-1:0] ACT_BYTE_END = 2'd1;
   localparam logic [ACT_W-1:0] ACT_END      = 2'd2;

   localparam logic [KIND_W-1:0] KIND_EOF      = 6'd0;
   localparam logic [KIND_W-1:0] KIND_WS       = 6'd1;
   localparam logic [KIND_W-1:0] KIND_STR      = 6'd2;
   localparam logic [KIND_W-1:0] KIND_INT      = 6'd3;
   localparam logic [KIND_W-1:0] KIND_REAL     = 6'd4;
   localparam logic [KIND_W-1:0] KIND_KEYWORD  = 6'd5;
   localparam logic [KIND_W-1:0] KIND_AMP      = 6'd6;
   localparam logic [KIND_W-1:0] KIND_IDENT    = 6'd7;
   localparam logic [KIND_W-1:0] KIND_END      = 6'd8;
   localparam logic [KIND_W-1:0] KIND_STARSTAR = 6'd9;
   localparam logic [KIND_W-1:0] KIND_OP_BASE  = 6'd10;
   localparam logic [KIND_W-1:0] KIND_STAR     = 6'd12;
   localparam logic [KIND_W-1:0] KIND_DOT      = 6'd20;
   localparam logic [KIND_W-1:0] KIND_ERR      = 6'd32;

   localparam logic [MATCH_W-1:0] MATCH_NONE = 3'd0;
   localparam logic [MATCH_W-1:0] MATCH_E    = 3'd1;
   localparam logic [MATCH_W-1:0] MATCH_EN   = 3'd2;
   localparam logic [MATCH_W-1:0] MATCH_END  = 3'd3;
   localparam logic [MATCH_W-1:0] MATCH_FAIL = 3'd4;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_WS,
      MODE_SQ,
      MODE_DQ,
      MODE_INT,
      MODE_INTDOT,
      MODE_FRAC,
      MODE_EXP,
      MODE_EXPD,
      MODE_AMP,
      MODE_IDENT,
      MODE_STAR
   } mode_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] length;
      logic [VAL_W-1:0]   value;
   } token_type;

   typedef struct packed {
      logic [1:0] valid;
      token_type  second;
      token_type  first;
   } close_type;

   typedef struct packed {
      logic [CNT_W-1:0]              count;
      token_type [MAX_RES-1:0]       tok;
   } burst_type;

   function automatic logic is_digit(logic [CHAR_W-1:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [CHAR_W-1:0] c);
      return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
   endfunction

   function automatic logic is_ws(logic [CHAR_W-1:0] c);
      return (c == " ") || (c == 8'h09);
   endfunction

   function automatic logic is_name(logic [CHAR_W-1:0] c);
      return is_alpha(c) || is_digit(c) || (c == "_");
   endfunction

   function automatic logic [MATCH_W-1:0] end_next(logic [MATCH_W-1:0] m,
                                                   logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] u;
      u = ((c >= "a") && (c <= "z")) ? (c - 8'd32) : c;
      if ((m == MATCH_NONE) && (u == "E")) return MATCH_E;
      if ((m == MATCH_E) && (u == "N")) return MATCH_EN;
      if ((m == MATCH_EN) && (u == "D")) return MATCH_END;
      return MATCH_FAIL;
   endfunction

   function automatic logic [KIND_W-1:0] op_kind(logic [CHAR_W-1:0] c);
      logic [KIND_W-1:0] k;
      case (c)
         "+":     k = KIND_OP_BASE + 6'd0;
         "-":     k = KIND_OP_BASE + 6'd1;
         "*":     k = KIND_OP_BASE + 6'd2;
         "/":     k = KIND_OP_BASE + 6'd3;
         "%":     k = KIND_OP_BASE + 6'd4;
         "^":     k = KIND_OP_BASE + 6'd5;
         "!":     k = KIND_OP_BASE + 6'd6;
         "@":     k = KIND_OP_BASE + 6'd7;
         "~":     k = KIND_OP_BASE + 6'd8;
         "$":     k = KIND_OP_BASE + 6'd9;
         ".":     k = KIND_OP_BASE + 6'd10;
         "#":     k = KIND_OP_BASE + 6'd11;
         "|":     k = KIND_OP_BASE + 6'd12;
         "=":     k = KIND_OP_BASE + 6'd13;
         "?":     k = KIND_OP_BASE + 6'd14;
         ",":     k = KIND_OP_BASE + 6'd15;
         "(":     k = KIND_OP_BASE + 6'd16;
         ")":     k = KIND_OP_BASE + 6'd17;
         "[":     k = KIND_OP_BASE + 6'd18;
         "]":     k = KIND_OP_BASE + 6'd19;
         "<":     k = KIND_OP_BASE + 6'd20;
         ">":     k = KIND_OP_BASE + 6'd21;
         default: k = KIND_ERR;
      endcase
      return k;
   endfunction

   function automatic logic [FIELD_W-1:0] sat16(ofs_type v);
      logic [OFS_W+FIELD_W-1:0] w;
      w = (OFS_W + FIELD_W)'(v);
      if (w > (OFS_W + FIELD_W)'(FIELD_MAX)) return '1;
      return w[FIELD_W-1:0];
   endfunction

   function automatic token_type mk_tok(logic [KIND_W-1:0] kind, ofs_type at,
                                        ofs_type n, logic [VAL_W-1:0] value);
      token_type t;
      t.kind   = kind;
      t.start  = sat16(at);
      t.length = sat16(n);
      t.value  = value;
      return t;
   endfunction

   function automatic close_type close_tokens(mode_type mode, ofs_type ts, ofs_type e,
                                              logic [VAL_W-1:0] acc,
                                              logic [MATCH_W-1:0] match);
      close_type r;
      ofs_type   n;
      n        = e - ts;
      r.valid  = 2'b01;
      r.first  = mk_tok(KIND_WS, ts, n, '0);
      r.second = mk_tok(KIND_DOT, e - OFS_ONE, OFS_ONE, '0);
      case (mode) inside
         MODE_WS:                        r.first = mk_tok(KIND_WS, ts, n, '0);
         MODE_SQ, MODE_DQ:               r.first = mk_tok(KIND_STR, ts, n, '0);
         MODE_INT:                       r.first = mk_tok(KIND_INT, ts, n, acc);
         MODE_INTDOT: begin
            r.first = mk_tok(KIND_INT, ts, n - OFS_ONE, acc);
            r.valid = 2'b11;
         end
         MODE_FRAC, MODE_EXP, MODE_EXPD: r.first = mk_tok(KIND_REAL, ts, n, '0);
         MODE_AMP:
            r.first = mk_tok((n != '0) ? KIND_KEYWORD : KIND_AMP, ts, n, '0);
         MODE_IDENT:
            r.first = mk_tok((match == MATCH_END) ? KIND_END : KIND_IDENT, ts, n, '0);
         MODE_STAR:                      r.first = mk_tok(KIND_STAR, ts, OFS_ONE, '0);
         default:                        r.valid = 2'b00;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/source_tokenizer.sv @@
// Output: an accepted word's tokens are registered and appear on rsp next cycle.
// Throughput: one word per cycle while each word yields at most one token and
// rsp is ready; a word that yields more tokens (up to four) stalls req while
// the result buffer drains one token per cycle, as rsp takes them.
// Reset: synchronous, active high; clears the scan state, the result buffer
// and the line tag.
// ----------------------------------------------------------------------------
// source_tokenizer: streaming lexer for one statement field
// Scans one source byte per word and emits tokens with offsets and values.
// ----------------------------------------------------------------------------
module source_tokenizer
   import stok_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CHAR_W-1:0]     req_tdata,    // char_byte
   input  logic [ACT_W-1:0]      req_tuser,    // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // start_offset, token_length,
                                               // int_value, line_number, pad
   output logic [KIND_W-1:0]     rsp_tuser,    // token_kind
   output logic                  rsp_tlast,    // last_of_run
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic               accept;
   logic               space;
   burst_type          burst;
   logic [FIELD_W-1:0] line_tag;

   assign req_tready = space;
   assign accept     = req_tvalid & space;

   stok_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .line_tag    (line_tag)
   );

   stok_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .action    (req_tuser),
      .char_byte (req_tdata),
      .burst     (burst)
   );

   stok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .burst      (burst),
      .line_tag   (line_tag),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/stok_csr.sv @@
// ----------------------------------------------------------------------------
// stok_csr: configuration register port
// Holds the line tag written over the APB-style port and reads it back.
// ----------------------------------------------------------------------------
module stok_csr
   import stok_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [FIELD_W-1:0]    line_tag
);

   logic [FIELD_W-1:0]   tag_ff;
   logic [FIELD_W-1:0]   tag_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign line_tag   = tag_ff;

   always_comb begin
      tag_in     = tag_ff;
      csr_prdata = '0;
      unique case (reg_idx)
         REG_LINE_TAG: begin
            csr_prdata = CSR_DATA_W'(tag_ff);
            if (wr_en) tag_in = csr_pwdata[FIELD_W-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

endmodule

@@ rtl/stok_scan.sv @@
// ----------------------------------------------------------------------------
// stok_scan: per-byte scanner
// Advances the scan state on each accepted word and forms the token burst.
// ----------------------------------------------------------------------------
module stok_scan
   import stok_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [ACT_W-1:0]  action,
   input  logic [CHAR_W-1:0] char_byte,
   output burst_type         burst
);

   localparam int NSLOT = 6;

   mode_type            mode_ff, mode_in, mode_f;
   ofs_type             start_ff, start_in, start_f;
   ofs_type             offset_ff, offset_in, offset_f;
   logic [VAL_W-1:0]    acc_ff, acc_in, acc_f;
   logic [MATCH_W-1:0]  match_ff, match_in, match_f;
   logic                do_feed;
   logic                field_end;
   logic                restart;
   close_type           feed_close;
   close_type           end_close;
   logic                emit_v;
   token_type           emit_t;
   logic [VAL_W+3:0]    acc_x10;
   logic [NSLOT-1:0]    slot_v;
   token_type           slot_t [NSLOT];
   logic [CNT_W-1:0]    n;

   always_comb begin
      do_feed   = accept && ((action == ACT_BYTE) || (action == ACT_BYTE_END)) &&
                  (offset_ff < OFS_MAX);
      field_end = accept && (action != ACT_BYTE);
      acc_x10   = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                  (VAL_W + 4)'(char_byte[3:0]);

      mode_f     = mode_ff;
      start_f    = start_ff;
      acc_f      = acc_ff;
      match_f    = match_ff;
      restart    = 1'b0;
      emit_v     = 1'b0;
      emit_t     = mk_tok(KIND_ERR, offset_ff, OFS_ONE, '0);
      feed_close = '0;

      if (do_feed) begin
         unique case (mode_ff) inside
            MODE_IDLE: restart = 1'b1;
            MODE_WS:   restart = !is_ws(char_byte);
            MODE_SQ, MODE_DQ: begin
               if (((mode_ff == MODE_SQ) && (char_byte == "'")) ||
                   ((mode_ff == MODE_DQ) && (char_byte == "\""))) begin
                  emit_v = 1'b1;
                  emit_t = mk_tok(KIND_STR, start_ff, offset_ff - start_ff, '0);
                  mode_f = MODE_IDLE;
               end
            end
            MODE_INT: begin
               if (is_digit(char_byte)) begin
                  acc_f = (acc_x10[VAL_W+3:VAL_W] != '0) ? '1 : acc_x10[VAL_W-1:0];
               end else if (char_byte == ".") begin
                  mode_f = MODE_INTDOT;
               end else if ((char_byte == "e") || (char_byte == "E")) begin
                  mode_f = MODE_EXP;
               end else begin
                  restart = 1'b1;
               end
            end
            MODE_INTDOT: begin
               if (is_digit(char_byte)) mode_f = MODE_FRAC;
               else restart = 1'b1;
            end
            MODE_FRAC: begin
               if ((char_byte == "e") || (char_byte == "E")) mode_f = MODE_EXP;
               else if (!is_digit(char_byte)) restart = 1'b1;
            end
            MODE_EXP: begin
               if ((char_byte == "+") || (char_byte == "-") || is_digit(char_byte)) begin
                  mode_f = MODE_EXPD;
               end else begin
                  restart = 1'b1;
               end
            end
            MODE_EXPD: restart = !is_digit(char_byte);
            MODE_AMP:  restart = !is_name(char_byte);
            MODE_IDENT: begin
               if (is_name(char_byte) || (char_byte == ".") || char_byte[CHAR_W-1]) begin
                  match_f = end_next(match_ff, char_byte);
               end else begin
                  restart = 1'b1;
               end
            end
            MODE_STAR: begin
               if (char_byte == "*") begin
                  emit_v = 1'b1;
                  emit_t = mk_tok(KIND_STARSTAR, start_ff, OFS_TWO, '0);
                  mode_f = MODE_IDLE;
               end else begin
                  restart = 1'b1;
               end
            end
            default: restart = 1'b1;
         endcase

         if (restart) begin
            feed_close = close_tokens(mode_ff, start_ff, offset_ff, acc_ff, match_ff);
            start_f    = offset_ff;
            mode_f     = MODE_IDLE;
            if (is_ws(char_byte)) begin
               mode_f = MODE_WS;
            end else if (char_byte == "'") begin
               mode_f  = MODE_SQ;
               start_f = offset_ff + OFS_ONE;
            end else if (char_byte == "\"") begin
               mode_f  = MODE_DQ;
               start_f = offset_ff + OFS_ONE;
            end else if (is_digit(char_byte)) begin
               mode_f = MODE_INT;
               acc_f  = VAL_W'(char_byte[3:0]);
            end else if (char_byte == "&") begin
               mode_f  = MODE_AMP;
               start_f = offset_ff + OFS_ONE;
            end else if (is_alpha(char_byte) || char_byte[CHAR_W-1]) begin
               mode_f  = MODE_IDENT;
               match_f = end_next(MATCH_NONE, char_byte);
            end else if (char_byte == "*") begin
               mode_f = MODE_STAR;
            end else begin
               emit_v = 1'b1;
               emit_t = mk_tok(op_kind(char_byte), offset_ff, OFS_ONE, '0);
            end
         end
      end

      offset_f  = do_feed ? (offset_ff + OFS_ONE) : offset_ff;
      end_close = '0;
      if (field_end) begin
         end_close = close_tokens(mode_f, start_f, offset_f, acc_f, match_f);
      end

      mode_in   = field_end ? MODE_IDLE  : mode_f;
      start_in  = field_end ? '0         : start_f;
      offset_in = field_end ? '0         : offset_f;
      acc_in    = field_end ? '0         : acc_f;
      match_in  = field_end ? MATCH_NONE : match_f;

      slot_v = {field_end, end_close.valid, emit_v, feed_close.valid};
      slot_t[0] = feed_close.first;
      slot_t[1] = feed_close.second;
      slot_t[2] = emit_t;
      slot_t[3] = end_close.first;
      slot_t[4] = end_close.second;
      slot_t[5] = mk_tok(KIND_EOF, offset_f, '0, '0);

      // pack the live slots in order, keep the first MAX_RES (four)
      n         = '0;
      burst.tok = '0;
      for (int i = 0; i < NSLOT; i++) begin
         if (slot_v[i] && (n < CNT_W'(MAX_RES))) begin
            burst.tok[n[RD_W-1:0]] = slot_t[i];
            n = n + 1'b1;
         end
      end
      burst.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         start_ff  <= '0;
         offset_ff <= '0;
         acc_ff    <= '0;
         match_ff  <= MATCH_NONE;
      end else begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
         acc_ff    <= acc_in;
         match_ff  <= match_in;
      end
   end

endmodule

@@ rtl/stok_queue.sv @@
// ----------------------------------------------------------------------------
// stok_queue: token result buffer
// Holds the burst of one input word and hands its tokens out one at a time.
// ----------------------------------------------------------------------------
module stok_queue
   import stok_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  burst_type             burst,
   input  logic [FIELD_W-1:0]    line_tag,
   output logic                  space,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);

   token_type [MAX_RES-1:0] tok_ff;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [RD_W-1:0]         rd_ff, rd_in;
   token_type               head;
   logic                    pop;

   assign head       = tok_ff[rd_ff];
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tlast  = (cnt_ff == CNT_W'(1));
   assign rsp_tuser  = head.kind;
   assign rsp_tdata  = RSP_DATA_W'({line_tag, head.value, head.length, head.start});
   assign pop        = rsp_tvalid & rsp_tready;
   assign space      = (cnt_ff == '0) || (pop && rsp_tlast);

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (load) begin
         cnt_in = burst.count;
         rd_in  = '0;
      end else if (pop) begin
         cnt_in = cnt_ff - 1'b1;
         rd_in  = rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) tok_ff <= burst.tok;
   end

endmodule
